@@ rtl/dst_pkg.sv @@
package dst_pkg;

   localparam int DST_NUM_ELEMENTS = 1024;
   localparam int DST_NUM_LEVELS   = 10;

   localparam int DATA_W    = 32;
   localparam int POS_W     = 10;
   localparam int CNT_W     = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDENTITY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEM_COUNT = 2'd2;

   typedef enum logic [1:0] {
      OPC_LOAD  = 2'd0,
      OPC_BUILD = 2'd1,
      OPC_QUERY = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      OP_MIN = 2'd0,
      OP_MAX = 2'd1,
      OP_SUM = 2'd2,
      OP_XOR = 2'd3
   } op_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_QUERY,
      ST_BUILD,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      opcode_type                opcode;
      logic [POS_W-1:0]          left_pos;
      logic [POS_W-1:0]          right_pos;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  answer;
      logic                      empty_range;
      logic                      build_done;
   } rsp_type;

endpackage

@@ rtl/dst_combine.sv @@
module dst_combine
   import dst_pkg::*;
(
   input  op_mode_type              op_mode,
   input  logic signed [DATA_W-1:0] a,
   input  logic signed [DATA_W-1:0] b,
   output logic signed [DATA_W-1:0] y
);

   logic a_less;

   assign a_less = (a < b);

   always_comb begin
      case (op_mode)
         OP_MIN:  y = a_less ? a : b;
         OP_MAX:  y = a_less ? b : a;
         OP_SUM:  y = a + b;
         OP_XOR:  y = a ^ b;
         default: y = a ^ b;
      endcase
   end

endmodule

@@ rtl/disjoint_sparse_table_range_query_unit.sv @@
// Load: busy stays low, no response.
// Query: busy for 1 cycle, response strobed from a register after it; no new request while busy.
// Build: the shared combiner walks one table entry per cycle, then a drain state
//   follows, and the done response is strobed as busy drops.
// Reset clears the control state and the configuration registers only; the element
// store and the level table hold garbage until loaded and built.
module disjoint_sparse_table_range_query_unit
   import dst_pkg::*;
#(
   parameter int NUM_ELEMENTS = DST_NUM_ELEMENTS,
   parameter int NUM_LEVELS   = DST_NUM_LEVELS
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  req_type              req_data,
   output logic                 busy,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W     = $clog2(NUM_ELEMENTS);
   localparam int LV        = (NUM_LEVELS < IDX_W) ? NUM_LEVELS : IDX_W;
   localparam int LVW       = (LV > 1) ? $clog2(LV) : 1;
   localparam int TBL_DEPTH = LV * NUM_ELEMENTS;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int CW        = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

   // configuration
   op_mode_type              op_mode_ff;
   logic signed [DATA_W-1:0] identity_ff;
   logic [CNT_W-1:0]         count_ff;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;
   logic      accept;

   // request decode
   logic [IDX_W+POS_W-1:0] l_ext, r_ext;
   logic [IDX_W-1:0]       l_idx, r_idx, qx;
   logic [LVW-1:0]         hsel;
   logic [TBL_AW-1:0]      q_addr_a, q_addr_b;

   // query operands
   logic signed [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic                     empty_ff, same_ff;

   // build sequencer
   logic [IDX_W-1:0] cnt_ff;
   logic [LVW-1:0]   lvl_ff;
   logic [IDX_W-1:0] half_mask, low_mask, iss_pos;
   logic             iss_first, iss_pad, build_last;

   logic [IDX_W-1:0]         pos_p_ff;
   logic [LVW-1:0]           lvl_p_ff;
   logic                     first_p_ff, pad_p_ff, wr_vld_ff;
   logic signed [DATA_W-1:0] elem_rd_ff, acc_ff;
   logic signed [DATA_W-1:0] operand, build_y;
   logic [TBL_AW-1:0]        wr_addr;

   // shared combiner
   logic signed [DATA_W-1:0] comb_a, comb_b, comb_y;

   logic signed [DATA_W-1:0] elem_mem [NUM_ELEMENTS];
   logic signed [DATA_W-1:0] tbl_mem  [TBL_DEPTH];

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start & ~busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff  <= OP_MIN;
         identity_ff <= '0;
         count_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OP_MODE:    op_mode_ff  <= op_mode_type'(csr_wdata[1:0]);
            CSR_IDENTITY:   identity_ff <= csr_wdata;
            CSR_ELEM_COUNT: count_ff    <= csr_wdata[CNT_W-1:0];
            default:        op_mode_ff  <= op_mode_ff;
         endcase
      end
   end

   // positions wrap modulo the array size
   assign l_ext = {{IDX_W{1'b0}}, req_data.left_pos};
   assign r_ext = {{IDX_W{1'b0}}, req_data.right_pos};
   assign l_idx = l_ext[IDX_W-1:0];
   assign r_idx = r_ext[IDX_W-1:0];
   assign qx    = l_idx ^ r_idx;

   // level from the highest differing bit, held to the top built level
   always_comb begin
      hsel = '0;
      for (int k = 0; k < IDX_W; k++) begin
         if (qx[k]) begin
            hsel = (k < LV) ? LVW'(k) : LVW'(LV - 1);
         end
      end
   end

   assign q_addr_a = TBL_AW'({hsel, l_idx});
   assign q_addr_b = TBL_AW'({hsel, r_idx});

   // walk each block from the midpoint outward: left half inverted, right half straight
   assign half_mask  = IDX_W'(1) << lvl_ff;
   assign low_mask   = half_mask - IDX_W'(1);
   assign iss_pos    = ((cnt_ff & half_mask) != '0) ? cnt_ff : (cnt_ff ^ low_mask);
   assign iss_first  = ((cnt_ff & low_mask) == '0);
   assign iss_pad    = (CW'(iss_pos) >= CW'(count_ff));
   assign build_last = (cnt_ff == '1) && (lvl_ff == LVW'(LV - 1));

   assign operand = pad_p_ff ? identity_ff : elem_rd_ff;
   assign build_y = first_p_ff ? operand : comb_y;
   assign wr_addr = TBL_AW'({lvl_p_ff, pos_p_ff});

   assign comb_a = (state_ff == ST_QUERY) ? rd_a_ff : acc_ff;
   assign comb_b = (state_ff == ST_QUERY) ? rd_b_ff : operand;

   dst_combine u_combine (
      .op_mode (op_mode_ff),
      .a       (comb_a),
      .b       (comb_b),
      .y       (comb_y)
   );

   always_ff @(posedge clock) begin
      if (accept && req_data.opcode == OPC_LOAD) begin
         elem_mem[l_idx] <= req_data.value;
      end
      if (state_ff == ST_BUILD) begin
         elem_rd_ff <= elem_mem[iss_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_vld_ff) begin
         tbl_mem[wr_addr] <= build_y;
      end
      if (accept && req_data.opcode == OPC_QUERY) begin
         rd_a_ff <= tbl_mem[q_addr_a];
         rd_b_ff <= tbl_mem[q_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.opcode == OPC_QUERY) begin
         empty_ff <= (l_idx > r_idx);
         same_ff  <= (l_idx == r_idx);
      end
      pos_p_ff   <= iss_pos;
      lvl_p_ff   <= lvl_ff;
      first_p_ff <= iss_first;
      pad_p_ff   <= iss_pad;
      if (wr_vld_ff) begin
         acc_ff <= build_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         lvl_ff    <= '0;
         wr_vld_ff <= 1'b0;
      end else begin
         wr_vld_ff <= (state_ff == ST_BUILD);
         if (accept && req_data.opcode == OPC_BUILD) begin
            cnt_ff <= '0;
            lvl_ff <= '0;
         end else if (state_ff == ST_BUILD) begin
            cnt_ff <= cnt_ff + IDX_W'(1);
            if (cnt_ff == '1) begin
               lvl_ff <= lvl_ff + LVW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.opcode)
                  OPC_BUILD: state_in = ST_BUILD;
                  OPC_QUERY: state_in = ST_QUERY;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_QUERY: begin
            state_in                = ST_IDLE;
            rsp_valid_in            = 1'b1;
            rsp_data_in.empty_range = empty_ff;
            rsp_data_in.answer      = empty_ff ? identity_ff :
                                      same_ff  ? rd_a_ff : comb_y;
         end
         ST_BUILD: begin
            if (build_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last table write lands at the end of this cycle
            state_in               = ST_IDLE;
            rsp_valid_in           = 1'b1;
            rsp_data_in.build_done = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
